/* design/cal_pkg.sv */
`default_nettype none

package cal_pkg;

    localparam int CARD_UID_W = 40;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 2;

    // request kinds
    localparam logic [ACTION_W-1:0] ACT_SCAN   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd3;

    // result codes
    localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXISTS  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAVED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DELETED = 3'd6;
    localparam logic [STATUS_W-1:0] ST_FLUSHED = 3'd7;

    typedef struct packed {
        logic load;    // capture the request
        logic cmp;     // register the match vector
        logic commit;  // update the table and issue the result
    } t_cal_cmd;

    typedef struct packed {
        logic is_flush;
    } t_cal_stat;

endpackage

`default_nettype wire

/* design/card_access_list_table_top.sv */
// channel   handshake        payload
// request   start / busy     i_action, i_card_uid
// result    o_done strobe    o_status, o_slot
//
// an accepted request is captured, then the per-slot compare is registered, then
// the table is updated and the result registered; a flush skips the compare.
// busy is high from the cycle after accept until the table update is done.
// the result is on the ports in the single cycle that o_done is high and is held until the next result.
// i_rst_n is synchronous and leaves every slot empty.
`default_nettype none

module card_access_list_table_top
    import cal_pkg::*;
#(
    parameter int SLOTS    = 4,
    parameter int UID_BITS = 40
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ACTION_W-1:0]   i_action,
    input  wire logic [CARD_UID_W-1:0] i_card_uid,
    output logic                       o_done,
    output logic [STATUS_W-1:0]        o_status,
    output logic [SLOT_W-1:0]          o_slot
);

    t_cal_cmd  w_cmd;
    t_cal_stat w_stat;

    cal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    cal_dpath #(
        .SLOTS    (SLOTS),
        .UID_BITS (UID_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_action   (i_action),
        .i_card_uid (i_card_uid),
        .o_stat     (w_stat),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_slot     (o_slot)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_UNKNOWN || o_status == ST_NONE ||
                    o_status == ST_NOSPACE || o_status == ST_FLUSHED))
        |-> (o_slot == '0))
        else $error("slot not zero for a result without a slot");

endmodule

`default_nettype wire

/* design/cal_ctrl.sv */
`default_nettype none

module cal_ctrl
    import cal_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_cal_stat i_stat,
    output t_cal_cmd  o_cmd,
    output logic      o_busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CMP    = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                // flush needs no lookup
                if (i_stat.is_flush) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.cmp = 1'b1;
                    n_state   = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* design/cal_dpath.sv */
`default_nettype none

module cal_dpath
    import cal_pkg::*;
#(
    parameter int SLOTS    = 4,
    parameter int UID_BITS = 40
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cal_cmd              i_cmd,
    input  wire logic [ACTION_W-1:0]   i_action,
    input  wire logic [CARD_UID_W-1:0] i_card_uid,
    output t_cal_stat                  o_stat,
    output logic                       o_done,
    output logic [STATUS_W-1:0]        o_status,
    output logic [SLOT_W-1:0]          o_slot
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [UID_BITS-1:0] w_uid;

    generate
        if (UID_BITS <= CARD_UID_W) begin : g_trim
            assign w_uid = i_card_uid[UID_BITS-1:0];
        end else begin : g_ext
            assign w_uid = {{(UID_BITS-CARD_UID_W){1'b0}}, i_card_uid};
        end
    endgenerate

    logic [ACTION_W-1:0] r_action;
    logic [UID_BITS-1:0] r_uid;
    logic [UID_BITS-1:0] r_store [SLOTS];
    logic [SLOTS-1:0]    r_valid;
    logic [SLOTS-1:0]    r_match;
    logic                r_done;
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0]   r_slot;

    logic [SLOTS-1:0]    n_valid;
    logic [STATUS_W-1:0] n_status;
    logic [IDX_W-1:0]    n_idx;
    logic                n_write;

    logic [IDX_W-1:0]    w_m_idx;
    logic                w_m_hit;
    logic [IDX_W-1:0]    w_f_idx;
    logic                w_f_hit;
    logic                w_any;
    logic [IDX_W+1:0]    w_idx_ext;

    // lowest index wins: lowest set match bit, lowest empty slot
    always_comb begin
        w_m_idx = '0;
        w_m_hit = 1'b0;
        w_f_idx = '0;
        w_f_hit = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_m_idx = IDX_W'(i);
                w_m_hit = 1'b1;
            end
            if (!r_valid[i]) begin
                w_f_idx = IDX_W'(i);
                w_f_hit = 1'b1;
            end
        end
    end

    assign w_any = |r_valid;

    always_comb begin
        n_valid  = r_valid;
        n_status = ST_UNKNOWN;
        n_idx    = '0;
        n_write  = 1'b0;
        unique case (r_action)
            ACT_SCAN: begin
                if (!w_any) begin
                    n_status = ST_NONE;
                end else if (w_m_hit) begin
                    n_status = ST_GRANTED;
                    n_idx    = w_m_idx;
                end
            end
            ACT_ADD: begin
                if (w_m_hit) begin
                    n_status = ST_EXISTS;
                    n_idx    = w_m_idx;
                end else if (w_f_hit) begin
                    n_status         = ST_SAVED;
                    n_idx            = w_f_idx;
                    n_write          = 1'b1;
                    n_valid[w_f_idx] = 1'b1;
                end else begin
                    n_status = ST_NOSPACE;
                end
            end
            ACT_DELETE: begin
                if (!w_any) begin
                    n_status = ST_NONE;
                end else if (w_m_hit) begin
                    n_status         = ST_DELETED;
                    n_idx            = w_m_idx;
                    n_valid[w_m_idx] = 1'b0;
                end
            end
            ACT_FLUSH: begin
                n_status = ST_FLUSHED;
                n_valid  = '0;
            end
            default: begin
                n_status = ST_UNKNOWN;
            end
        endcase
    end

    assign w_idx_ext = {2'b00, n_idx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_uid    <= w_uid;
        end
        if (i_cmd.cmp) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_match[i] <= r_valid[i] && (r_store[i] == r_uid);
            end
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_slot   <= w_idx_ext[SLOT_W-1:0];
            if (n_write) begin
                r_store[n_idx] <= r_uid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.commit) begin
                r_valid <= n_valid;
            end
        end
    end

    assign o_stat.is_flush = (r_action == ACT_FLUSH);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_slot          = r_slot;

endmodule

`default_nettype wire

/* test/tb_card_access_list_table_top.sv */
`timescale 1ns / 100ps

module tb_card_access_list_table_top;
    import cal_pkg::*;

    localparam int TABLE_SLOTS = 4;
    localparam int IDLE_LIMIT  = 1000;
    localparam int DRAIN_TAIL  = 10;
    localparam int RANDOM_WORDS = 2000;
    localparam int POOL_SIZE   = 6;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } outcome_t;

    // shadow copy of the card table, predicts the result word of every request
    class card_table_tracker;
        logic [CARD_UID_W-1:0] stored_uid [TABLE_SLOTS];
        bit                    slot_used  [TABLE_SLOTS];
        outcome_t              outcome_q  [$];
        int                    errors;

        function new();
            errors = 0;
            foreach (slot_used[i]) begin
                slot_used[i]  = 1'b0;
                stored_uid[i] = '0;
            end
        endfunction

        function void note_request(logic [ACTION_W-1:0] act, logic [CARD_UID_W-1:0] uid);
            outcome_t res;
            int       hit;
            int       free_slot;
            bit       any_used;
            hit       = -1;
            free_slot = -1;
            any_used  = 1'b0;
            // lowest matching valid slot and lowest free slot
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot_used[i]) begin
                    any_used = 1'b1;
                    if (hit < 0 && stored_uid[i] == uid)
                        hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            res.status = ST_UNKNOWN;
            res.slot   = '0;
            case (act)
                ACT_SCAN: begin
                    if (!any_used) begin
                        res.status = ST_NONE;
                    end else if (hit >= 0) begin
                        res.status = ST_GRANTED;
                        res.slot   = SLOT_W'(hit);
                    end
                end
                ACT_ADD: begin
                    if (hit >= 0) begin
                        res.status = ST_EXISTS;
                        res.slot   = SLOT_W'(hit);
                    end else if (free_slot >= 0) begin
                        stored_uid[free_slot] = uid;
                        slot_used[free_slot]  = 1'b1;
                        res.status = ST_SAVED;
                        res.slot   = SLOT_W'(free_slot);
                    end else begin
                        res.status = ST_NOSPACE;
                    end
                end
                ACT_DELETE: begin
                    if (!any_used) begin
                        res.status = ST_NONE;
                    end else if (hit >= 0) begin
                        slot_used[hit] = 1'b0;
                        res.status = ST_DELETED;
                        res.slot   = SLOT_W'(hit);
                    end
                end
                default: begin
                    foreach (slot_used[i])
                        slot_used[i] = 1'b0;
                    res.status = ST_FLUSHED;
                end
            endcase
            outcome_q.push_back(res);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot);
            outcome_t exp_res;
            if (outcome_q.size() == 0) begin
                $error("result word with nothing expected: status=%0d slot=%0d", status, slot);
                errors++;
                return;
            end
            exp_res = outcome_q.pop_front();
            if (status !== exp_res.status) begin
                $error("status: expected %0d, actual %0d", exp_res.status, status);
                errors++;
            end
            if (slot !== exp_res.slot) begin
                $error("slot: expected %0d, actual %0d", exp_res.slot, slot);
                errors++;
            end
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic [ACTION_W-1:0]   i_action   = ACT_SCAN;
    logic [CARD_UID_W-1:0] i_card_uid = '0;
    logic                  busy;
    logic                  o_done;
    logic [STATUS_W-1:0]   o_status;
    logic [SLOT_W-1:0]     o_slot;

    card_table_tracker tracker = new();
    int                idle_cycles = 0;
    logic [CARD_UID_W-1:0] uid_pool [POOL_SIZE];

    card_access_list_table_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_action   (i_action),
        .i_card_uid (i_card_uid),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_slot     (o_slot)
    );

    always #2 i_clk = ~i_clk;

    // sample both channels on the edge, values are the ones before the edge updates
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                tracker.note_request(i_action, i_card_uid);
            if (o_done)
                tracker.check_result(o_status, o_slot);
            if ((start && !busy) || o_done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [CARD_UID_W-1:0] random_uid();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[CARD_UID_W-1:0];
    endfunction

    // holds the word on the ports until the edge that takes it
    task automatic send_word(logic [ACTION_W-1:0] act, logic [CARD_UID_W-1:0] uid);
        start      <= 1'b1;
        i_action   <= act;
        i_card_uid <= uid;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic run_directed();
        logic [CARD_UID_W-1:0] ones;
        ones = '1;
        send_word(ACT_FLUSH, ones);                 // flush an empty table
        send_word(ACT_SCAN, '0);                    // nothing stored
        send_word(ACT_DELETE, ones);                // nothing stored
        send_word(ACT_ADD, '0);                     // empty table saves to slot 0
        send_word(ACT_ADD, ones);
        send_word(ACT_ADD, '0);                     // already stored
        send_word(ACT_SCAN, ones);
        send_word(ACT_SCAN, 40'h55_5555_5555);      // unknown
        send_word(ACT_DELETE, 40'hAA_AAAA_AAAA);    // unknown
        pause_sender(3);
        send_word(ACT_ADD, 40'hAA_AAAA_AAAA);
        send_word(ACT_ADD, 40'h55_5555_5555);
        send_word(ACT_ADD, 40'h12_3456_789A);       // table full
        send_word(ACT_SCAN, 40'h55_5555_5555);
        send_word(ACT_DELETE, ones);                // frees slot 1
        send_word(ACT_ADD, 40'h80_0000_0001);       // lowest free slot is 1
        send_word(ACT_SCAN, 40'h80_0000_0001);
        send_word(ACT_DELETE, '0);
        send_word(ACT_DELETE, '0);                  // already gone
        send_word(ACT_ADD, ones);
        send_word(ACT_FLUSH, '0);
        send_word(ACT_SCAN, ones);                  // empty after flush
        send_word(ACT_ADD, ones);
        send_word(ACT_FLUSH, 40'h5A_A5A5_5AA5);
        pause_sender(2);
    endtask

    task automatic run_random();
        int sent;
        int burst_len;
        int pick;
        logic [ACTION_W-1:0]   act;
        logic [CARD_UID_W-1:0] uid;
        sent = 0;
        foreach (uid_pool[k])
            uid_pool[k] = random_uid();
        while (sent < RANDOM_WORDS) begin
            burst_len = $urandom_range(1, 24);
            for (int n = 0; n < burst_len; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 38)
                    act = ACT_ADD;
                else if (pick < 70)
                    act = ACT_SCAN;
                else if (pick < 95)
                    act = ACT_DELETE;
                else
                    act = ACT_FLUSH;
                // a small pool of cards keeps hits, duplicates and a full table common
                if ($urandom_range(0, 99) < 5)
                    uid_pool[$urandom_range(0, POOL_SIZE - 1)] = random_uid();
                if ($urandom_range(0, 99) < 80)
                    uid = uid_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    uid = random_uid();
                send_word(act, uid);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
        end
        start <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* card_access_list_table_top.f */
design/cal_pkg.sv
design/cal_ctrl.sv
design/cal_dpath.sv
design/card_access_list_table_top.sv
test/tb_card_access_list_table_top.sv
